/* rtl/twcls_pkg.sv */
// ----------------------------------------------------------------------------
// twcls_pkg
// Shared sizes, opcodes, status codes and cache interface types for the
// two-way cache load/store unit.
// ----------------------------------------------------------------------------
package twcls_pkg;

    localparam int MEM_WORDS = 128;
    localparam int SET_COUNT = 8;
    localparam int REG_COUNT = 32;

    localparam int MEM_BITS  = $clog2(MEM_WORDS);
    localparam int SET_BITS  = $clog2(SET_COUNT);
    localparam int TAG_BITS  = MEM_BITS - SET_BITS;
    localparam int REG_BITS  = $clog2(REG_COUNT);
    localparam int DATA_BITS = 32;
    localparam int WA_BITS   = 15;

    localparam logic [5:0] OP_LOAD  = 6'd35;
    localparam logic [5:0] OP_STORE = 6'd43;

    localparam logic [DATA_BITS-1:0] INIT_OFFSET = 32'd5;

    typedef enum logic [2:0] {
        ST_READ_HIT   = 3'd0,
        ST_READ_MISS  = 3'd1,
        ST_WRITE_HIT  = 3'd2,
        ST_WRITE_MISS = 3'd3,
        ST_BAD_OP     = 3'd4,
        ST_ADDR_ERR   = 3'd5
    } status_t;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [DATA_BITS-1:0] data;
    } line_t;

    typedef struct packed {
        logic                 hit;
        logic                 hit_way;
        logic [DATA_BITS-1:0] hit_data;
        logic                 victim_way;
        logic                 victim_valid;
        logic [TAG_BITS-1:0]  victim_tag;
        logic [DATA_BITS-1:0] victim_data;
    } lookup_t;

    typedef struct packed {
        logic                en;
        logic [SET_BITS-1:0] set;
        logic                way;
        logic                line_we;
        line_t               line;
    } update_t;

endpackage

/* rtl/twcls_cache.sv */
// ----------------------------------------------------------------------------
// twcls_cache
// Two-way cache store: one tag/data memory per way with registered reads,
// plus valid and history bits per set held in flip-flops.
// ----------------------------------------------------------------------------
module twcls_cache (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [twcls_pkg::SET_BITS-1:0] rd_set,
    input  logic [twcls_pkg::SET_BITS-1:0] lk_set,
    input  logic [twcls_pkg::TAG_BITS-1:0] lk_tag,
    output twcls_pkg::lookup_t            lookup,
    input  twcls_pkg::update_t            upd
);
    import twcls_pkg::*;

    logic [1:0] valid_reg  [SET_COUNT];
    logic       recent_reg [SET_COUNT];
    line_t      rd_line    [2];

    for (genvar w = 0; w < 2; w++) begin : g_way
        line_t line_mem [SET_COUNT];
        line_t rd_line_reg;

        always_ff @(posedge aclk) begin
            if (upd.line_we && upd.way == 1'(w)) begin
                line_mem[upd.set] <= upd.line;
            end
            rd_line_reg <= line_mem[rd_set];
        end

        assign rd_line[w] = rd_line_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SET_COUNT; i++) begin
                valid_reg[i]  <= 2'b00;
                recent_reg[i] <= 1'b0;
            end
        end else if (upd.en) begin
            recent_reg[upd.set] <= (upd.way == 1'b0);
            if (upd.line_we) begin
                valid_reg[upd.set][upd.way] <= 1'b1;
            end
        end
    end

    logic hit0;
    logic hit1;
    logic vway;

    always_comb begin
        hit0 = valid_reg[lk_set][0] && (rd_line[0].tag == lk_tag);
        hit1 = valid_reg[lk_set][1] && (rd_line[1].tag == lk_tag);
        vway = recent_reg[lk_set];
        lookup.hit          = hit0 || hit1;
        lookup.hit_way      = !hit0;
        lookup.hit_data     = hit0 ? rd_line[0].data : rd_line[1].data;
        lookup.victim_way   = vway;
        lookup.victim_valid = valid_reg[lk_set][vway];
        lookup.victim_tag   = rd_line[vway].tag;
        lookup.victim_data  = rd_line[vway].data;
    end

endmodule

/* rtl/two_way_cache_load_store_unit_top.sv */
// ----------------------------------------------------------------------------
// two_way_cache_load_store_unit_top
// Load/store unit with a register file, a word memory and a two-way cache.
// An accepted transfer is registered with its memory and cache reads, runs in S_EXEC
// (write-back to the single-ported memory) and its result is registered for m_*,
// held in S_WAIT while m_ready is low; no new transfer is taken before then.
// Reset: after aresetn the unit sweeps main memory, one word per cycle, for
// all MEM_WORDS words (128) before s_ready first rises; registers and cache clear.
// ----------------------------------------------------------------------------
module two_way_cache_load_store_unit_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [5:0]                       s_func,
    input  logic [4:0]                       s_base_field,
    input  logic [4:0]                       s_target_reg,
    input  logic [15:0]                      s_offset,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [2:0]                       m_status,
    output logic                             m_way_used,
    output logic signed [twcls_pkg::DATA_BITS-1:0] m_data_value,
    output logic [twcls_pkg::WA_BITS-1:0]    m_word_address
);
    import twcls_pkg::*;

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_EXEC = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    typedef struct packed {
        status_t              status;
        logic                 way;
        logic [DATA_BITS-1:0] data;
        logic [WA_BITS-1:0]   wa;
    } result_t;

    state_t               state_reg, state_next;
    logic [MEM_BITS-1:0]  init_cnt_reg;
    logic [5:0]           func_reg;
    logic [REG_BITS-1:0]  rt_reg;
    logic [WA_BITS-1:0]   wa_reg;
    result_t              hold_reg;
    result_t              out_reg;
    logic                 m_valid_reg;

    logic [DATA_BITS-1:0] main_mem [MEM_WORDS];
    logic [DATA_BITS-1:0] mem_rd_reg;
    logic [DATA_BITS-1:0] regfile_reg [REG_COUNT];

    logic [16:0]          byte_addr;
    logic [WA_BITS-1:0]   wa_in;
    logic                 accept;
    logic                 out_free;

    logic [SET_BITS-1:0]  set_cur;
    logic [TAG_BITS-1:0]  tag_cur;
    logic [MEM_BITS-1:0]  back_addr;
    logic [DATA_BITS-1:0] rf_rd;
    lookup_t              lookup;
    update_t              upd;
    result_t              res;
    logic                 ex_mem_we;
    logic [MEM_BITS-1:0]  ex_mem_addr;
    logic [DATA_BITS-1:0] ex_mem_wdata;
    logic                 ex_rf_we;
    logic                 mem_we;
    logic [MEM_BITS-1:0]  mem_addr;
    logic [DATA_BITS-1:0] mem_wdata;
    logic                 is_load;
    logic                 is_store;

    assign byte_addr = {12'd0, s_base_field} + {1'b0, s_offset};
    assign wa_in     = byte_addr[16:2];
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign set_cur   = wa_reg[SET_BITS-1:0];
    assign tag_cur   = wa_reg[MEM_BITS-1:SET_BITS];
    assign back_addr = {lookup.victim_tag, set_cur};
    assign rf_rd     = regfile_reg[rt_reg];
    assign is_load   = (func_reg == OP_LOAD);
    assign is_store  = (func_reg == OP_STORE);

    twcls_cache u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_set  (wa_in[SET_BITS-1:0]),
        .lk_set  (set_cur),
        .lk_tag  (tag_cur),
        .lookup  (lookup),
        .upd     (upd)
    );

    always_comb begin
        res.status   = ST_BAD_OP;
        res.way      = 1'b0;
        res.data     = '0;
        res.wa       = wa_reg;
        upd          = '0;
        upd.set      = set_cur;
        ex_mem_we    = 1'b0;
        ex_mem_addr  = wa_reg[MEM_BITS-1:0];
        ex_mem_wdata = rf_rd;
        ex_rf_we     = 1'b0;
        if (!is_load && !is_store) begin
            res.status = ST_BAD_OP;
        end else if (wa_reg >= WA_BITS'(MEM_WORDS)) begin
            res.status = ST_ADDR_ERR;
        end else if (lookup.hit) begin
            res.way = lookup.hit_way;
            upd.en  = 1'b1;
            upd.way = lookup.hit_way;
            if (is_load) begin
                res.status = ST_READ_HIT;
                res.data   = lookup.hit_data;
                ex_rf_we   = 1'b1;
            end else begin
                res.status    = ST_WRITE_HIT;
                res.data      = rf_rd;
                upd.line_we   = 1'b1;
                upd.line.tag  = tag_cur;
                upd.line.data = rf_rd;
            end
        end else if (is_load) begin
            res.status    = ST_READ_MISS;
            res.way       = lookup.victim_way;
            res.data      = mem_rd_reg;
            ex_rf_we      = 1'b1;
            upd.en        = 1'b1;
            upd.way       = lookup.victim_way;
            upd.line_we   = 1'b1;
            upd.line.tag  = tag_cur;
            upd.line.data = mem_rd_reg;
            ex_mem_addr   = back_addr;
            ex_mem_wdata  = lookup.victim_data;
            ex_mem_we     = lookup.victim_valid &&
                            ({1'b0, back_addr} < (MEM_BITS + 1)'(MEM_WORDS));
        end else begin
            res.status = ST_WRITE_MISS;
            res.data   = rf_rd;
            ex_mem_we  = 1'b1;
        end
        if (state_reg != S_EXEC) begin
            upd.en      = 1'b0;
            upd.line_we = 1'b0;
            ex_mem_we   = 1'b0;
            ex_rf_we    = 1'b0;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = wa_in[MEM_BITS-1:0];
        mem_wdata = ex_mem_wdata;
        case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_addr  = init_cnt_reg;
                mem_wdata = DATA_BITS'(init_cnt_reg) + INIT_OFFSET;
            end
            S_EXEC: begin
                mem_we   = ex_mem_we;
                mem_addr = ex_mem_addr;
            end
            default: begin
                mem_we   = 1'b0;
                mem_addr = wa_in[MEM_BITS-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            main_mem[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= main_mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                regfile_reg[i] <= '0;
            end
        end else if (ex_rf_we) begin
            regfile_reg[rt_reg] <= res.data;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_INIT: begin
                if (init_cnt_reg == MEM_BITS'(MEM_WORDS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = out_free ? S_IDLE : S_WAIT;
            end
            S_WAIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_INIT) begin
                init_cnt_reg <= init_cnt_reg + 1'b1;
            end
            if ((state_reg == S_EXEC || state_reg == S_WAIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_func;
            rt_reg   <= s_target_reg;
            wa_reg   <= wa_in;
        end
        if (state_reg == S_EXEC) begin
            hold_reg <= res;
            if (out_free) begin
                out_reg <= res;
            end
        end else if (state_reg == S_WAIT && out_free) begin
            out_reg <= hold_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = out_reg.status;
    assign m_way_used     = out_reg.way;
    assign m_data_value   = out_reg.data;
    assign m_word_address = out_reg.wa;

    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_EXEC))
        else $error("Accepted transfer did not enter the execute state.");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EXEC || state_reg == S_WAIT))
        else $error("Result appeared without an executed transfer.");

    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_reg.status == ST_BAD_OP || out_reg.status == ST_ADDR_ERR))
        |-> (out_reg.way == 1'b0 && out_reg.data == '0))
        else $error("Error result carries way or data.");

    a_addr_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.status == ST_ADDR_ERR)
        |-> (out_reg.wa >= WA_BITS'(MEM_WORDS)))
        else $error("Address error flagged for an address in range.");

    a_writeback_differs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && ex_mem_we && is_load)
        |-> (ex_mem_addr != wa_reg[MEM_BITS-1:0]))
        else $error("Victim write-back targets the word being filled.");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-way cache load/store unit. A short table of
// directed accesses runs first, then random loads, stores, bad opcodes and
// out-of-range addresses under several idle and back-pressure patterns. Every
// result transfer is compared field by field with its table entry or with a
// local model of the register file, the memory and the cache.
// ----------------------------------------------------------------------------
module tb_top;
    import twcls_pkg::*;

    localparam int DIR_ROWS    = 20;
    localparam int HOLD_CYCLES = 100;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LINE_COUNT  = 2 * SET_COUNT;

    localparam logic [5:0] FUNC_MIN = 6'h00;
    localparam logic [5:0] FUNC_MAX = 6'h3F;

    typedef struct packed {
        status_t                status;
        logic                   way;
        logic [DATA_BITS-1:0]   data;
        logic [WA_BITS-1:0]     wa;
    } access_result_t;

    typedef struct packed {
        logic [5:0]     func;
        logic [4:0]     base;
        logic [4:0]     rt;
        logic [15:0]    off;
        logic           known;
        access_result_t res;
    } dir_row_t;

    localparam access_result_t NO_RESULT = '{ST_READ_HIT, 1'b0, 32'd0, 15'd0};

    logic                        aclk         = 1'b0;
    logic                        aresetn      = 1'b0;
    logic                        s_valid      = 1'b0;
    logic                        s_ready;
    logic [5:0]                  s_func       = '0;
    logic [4:0]                  s_base_field = '0;
    logic [4:0]                  s_target_reg = '0;
    logic [15:0]                 s_offset     = '0;
    logic                        m_valid;
    logic                        m_ready      = 1'b0;
    logic [2:0]                  m_status;
    logic                        m_way_used;
    logic signed [DATA_BITS-1:0] m_data_value;
    logic [WA_BITS-1:0]          m_word_address;

    logic [DATA_BITS-1:0] mem_words  [MEM_WORDS];
    logic [DATA_BITS-1:0] reg_words  [REG_COUNT];
    logic                 line_ok    [LINE_COUNT];
    logic                 line_mru   [LINE_COUNT];
    logic [TAG_BITS-1:0]  line_tags  [LINE_COUNT];
    logic [DATA_BITS-1:0] line_words [LINE_COUNT];

    access_result_t pending_results [$];
    dir_row_t       dir_table [DIR_ROWS];

    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    bit rx_hold_req    = 1'b0;
    int rx_hold_left   = 0;
    int mismatch_count = 0;
    int sent_count     = 0;
    int cycle_count    = 0;
    int status_seen [6] = '{default: 0};

    two_way_cache_load_store_unit_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_base_field   (s_base_field),
        .s_target_reg   (s_target_reg),
        .s_offset       (s_offset),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_way_used     (m_way_used),
        .m_data_value   (m_data_value),
        .m_word_address (m_word_address)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic access_result_t predict_access(input logic [5:0] f,
                                                      input logic [4:0] b,
                                                      input logic [4:0] r,
                                                      input logic [15:0] o);
        access_result_t      res;
        logic [16:0]         byte_addr;
        logic [WA_BITS-1:0]  wa;
        logic [TAG_BITS-1:0] tag;
        int                  set;
        int                  li;
        int                  hit_way;
        int                  back;
        byte_addr = {12'd0, b} + {1'b0, o};
        wa        = byte_addr[16:2];
        res       = '{ST_BAD_OP, 1'b0, 32'd0, wa};
        if (f != OP_LOAD && f != OP_STORE) begin
            res.status = ST_BAD_OP;
        end else if (wa >= MEM_WORDS) begin
            res.status = ST_ADDR_ERR;
        end else begin
            set     = wa % SET_COUNT;
            tag     = TAG_BITS'(wa / SET_COUNT);
            hit_way = -1;
            if (line_ok[set*2] && line_tags[set*2] == tag) begin
                hit_way = 0;
            end else if (line_ok[set*2+1] && line_tags[set*2+1] == tag) begin
                hit_way = 1;
            end
            if (hit_way >= 0) begin
                li      = set * 2 + hit_way;
                res.way = hit_way[0];
                if (f == OP_LOAD) begin
                    res.data   = line_words[li];
                    reg_words[r] = res.data;
                    res.status = ST_READ_HIT;
                end else begin
                    res.data       = reg_words[r];
                    line_words[li] = res.data;
                    res.status     = ST_WRITE_HIT;
                end
                line_mru[li]             = 1'b1;
                line_mru[set*2+1-hit_way] = 1'b0;
            end else if (f == OP_LOAD) begin
                res.way = line_mru[set*2];
                li      = set * 2 + res.way;
                line_mru[li]              = 1'b1;
                line_mru[set*2+1-res.way] = 1'b0;
                if (line_ok[li]) begin
                    back = line_tags[li] * SET_COUNT + set;
                    if (back < MEM_WORDS) mem_words[back] = line_words[li];
                end
                line_words[li] = mem_words[wa];
                line_ok[li]    = 1'b1;
                line_tags[li]  = tag;
                res.data       = line_words[li];
                reg_words[r]   = res.data;
                res.status     = ST_READ_MISS;
            end else begin
                res.data      = reg_words[r];
                mem_words[wa] = res.data;
                res.status    = ST_WRITE_MISS;
            end
        end
        return res;
    endfunction

    task automatic push_access(input logic [5:0] f, input logic [4:0] b,
                               input logic [4:0] r, input logic [15:0] o,
                               input logic known, input access_result_t typed);
        access_result_t pred;
        int             gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_base_field <= b;
        s_target_reg <= r;
        s_offset     <= o;
        do @(posedge aclk); while (!s_ready);
        pred = predict_access(f, b, r, o);
        pending_results.insert(pending_results.size(), known ? typed : pred);
        sent_count++;
    endtask

    task automatic send_random(input int count);
        logic [5:0]  f;
        logic [4:0]  b;
        logic [4:0]  r;
        logic [15:0] o;
        int          pick;
        int          wa;
        int          byte_addr;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                f = OP_LOAD;
            end else if (pick < 88) begin
                f = OP_STORE;
            end else begin
                do f = 6'($urandom_range(63)); while (f == OP_LOAD || f == OP_STORE);
            end
            pick = $urandom_range(99);
            if (pick < 90) begin
                if (pick < 45) begin
                    wa = $urandom_range(3) * SET_COUNT + $urandom_range(SET_COUNT - 1);
                end else begin
                    wa = $urandom_range(MEM_WORDS - 1);
                end
                byte_addr = wa * 4 + $urandom_range(3);
                b = 5'($urandom_range(byte_addr < 31 ? byte_addr : 31));
                o = 16'(byte_addr - int'(b));
            end else begin
                b = 5'($urandom_range(31));
                o = 16'($urandom_range(65535));
            end
            r = 5'($urandom_range(31));
            push_access(f, b, r, o, 1'b0, NO_RESULT);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    initial begin
        access_result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing pending: status %0d, word address %0d",
                           m_status, m_word_address);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d", want.status,
                               m_status);
                        mismatch_count++;
                    end
                    if (m_way_used !== want.way) begin
                        $error("way_used mismatch: expected %0d, actual %0d", want.way,
                               m_way_used);
                        mismatch_count++;
                    end
                    if (m_data_value !== want.data) begin
                        $error("data_value mismatch: expected 0x%08h, actual 0x%08h",
                               want.data, m_data_value);
                        mismatch_count++;
                    end
                    if (m_word_address !== want.wa) begin
                        $error("word_address mismatch: expected %0d, actual %0d", want.wa,
                               m_word_address);
                        mismatch_count++;
                    end
                    status_seen[want.status]++;
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_ready <= 1'b0;
            end else if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int i;
        int phase;
        dir_table[0]  = '{OP_LOAD, 5'd0, 5'd1, 16'd0, 1'b1,
                          '{ST_READ_MISS, 1'b0, 32'd5, 15'd0}};
        dir_table[1]  = '{OP_LOAD, 5'd0, 5'd2, 16'd3, 1'b1,
                          '{ST_READ_HIT, 1'b0, 32'd5, 15'd0}};
        dir_table[2]  = '{OP_LOAD, 5'd31, 5'd3, 16'd33, 1'b0, NO_RESULT};
        dir_table[3]  = '{OP_LOAD, 5'd0, 5'd4, 16'd32, 1'b0, NO_RESULT};
        dir_table[4]  = '{OP_STORE, 5'd0, 5'd1, 16'd64, 1'b0, NO_RESULT};
        dir_table[5]  = '{OP_STORE, 5'd4, 5'd3, 16'd0, 1'b0, NO_RESULT};
        dir_table[6]  = '{OP_LOAD, 5'd0, 5'd4, 16'd4, 1'b0, NO_RESULT};
        dir_table[7]  = '{FUNC_MIN, 5'd31, 5'd31, 16'hFFFF, 1'b1,
                          '{ST_BAD_OP, 1'b0, 32'd0, 15'd16391}};
        dir_table[8]  = '{FUNC_MAX, 5'd0, 5'd0, 16'd0, 1'b1,
                          '{ST_BAD_OP, 1'b0, 32'd0, 15'd0}};
        dir_table[9]  = '{OP_LOAD - 6'd1, 5'd5, 5'd7, 16'd100, 1'b1,
                          '{ST_BAD_OP, 1'b0, 32'd0, 15'd26}};
        dir_table[10] = '{OP_STORE + 6'd1, 5'd31, 5'd1, 16'd0, 1'b1,
                          '{ST_BAD_OP, 1'b0, 32'd0, 15'd7}};
        dir_table[11] = '{OP_LOAD, 5'd31, 5'd9, 16'hFFFF, 1'b1,
                          '{ST_ADDR_ERR, 1'b0, 32'd0, 15'd16391}};
        dir_table[12] = '{OP_STORE, 5'd0, 5'd1, 16'd512, 1'b1,
                          '{ST_ADDR_ERR, 1'b0, 32'd0, 15'd128}};
        dir_table[13] = '{OP_LOAD, 5'd31, 5'd6, 16'd480, 1'b0, NO_RESULT};
        dir_table[14] = '{OP_STORE, 5'd3, 5'd0, 16'd508, 1'b0, NO_RESULT};
        dir_table[15] = '{OP_LOAD, 5'd0, 5'd31, 16'h01FC, 1'b0, NO_RESULT};
        dir_table[16] = '{OP_LOAD, 5'd0, 5'd0, 16'd8, 1'b0, NO_RESULT};
        dir_table[17] = '{OP_STORE, 5'd0, 5'd0, 16'd12, 1'b0, NO_RESULT};
        dir_table[18] = '{OP_LOAD, 5'd21, 5'd5, 16'hAAAA, 1'b1,
                          '{ST_ADDR_ERR, 1'b0, 32'd0, 15'd10927}};
        dir_table[19] = '{OP_STORE, 5'd10, 5'd10, 16'h5555, 1'b1,
                          '{ST_ADDR_ERR, 1'b0, 32'd0, 15'd5463}};

        for (i = 0; i < MEM_WORDS; i++) mem_words[i] = i + INIT_OFFSET;
        for (i = 0; i < REG_COUNT; i++) reg_words[i] = '0;
        for (i = 0; i < LINE_COUNT; i++) begin
            line_ok[i]    = 1'b0;
            line_mru[i]   = 1'b0;
            line_tags[i]  = '0;
            line_words[i] = '0;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            push_access(dir_table[i].func, dir_table[i].base, dir_table[i].rt,
                        dir_table[i].off, dir_table[i].known, dir_table[i].res);
        end
        s_valid <= 1'b0;
        wait_drained();

        // The result side holds off while transfers keep coming, so the unit
        // fills up and drops s_ready; afterwards the sender waits for all results.
        rx_hold_req = 1'b1;
        send_random(24);
        s_valid <= 1'b0;
        wait_drained();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin tx_idle_pct = 37; rx_stall_pct = 37; end
            endcase
            send_random(119);
            s_valid <= 1'b0;
            wait_drained();
        end
        repeat (16) @(posedge aclk);

        $display("Sent %0d transfers: directed table, a long result hold-off %s",
                 sent_count, "and four idle mixes.");
        $display("Results seen: %0d read hit, %0d read miss, %0d write hit,",
                 status_seen[ST_READ_HIT], status_seen[ST_READ_MISS],
                 status_seen[ST_WRITE_HIT]);
        $display("  %0d write miss, %0d bad opcode, %0d address error.",
                 status_seen[ST_WRITE_MISS], status_seen[ST_BAD_OP],
                 status_seen[ST_ADDR_ERR]);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/twcls_pkg.sv
rtl/twcls_cache.sv
rtl/two_way_cache_load_store_unit_top.sv
sim/tb_top.sv
